/* rtl/core/hbs_pkg.sv */
// shared types, constants and bit search functions for the hierarchical bitset
package hbs_pkg;

  localparam int KEY_W      = 12;
  localparam int WORD_W     = 64;
  localparam int BIT_W      = 6;
  localparam int LEAF_W     = KEY_W - BIT_W;
  localparam int LEAF_WORDS = 1 << LEAF_W;
  localparam int OP_W       = 3;

  localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
  localparam logic [OP_W-1:0] OP_ERASE  = 3'd1;
  localparam logic [OP_W-1:0] OP_TEST   = 3'd2;
  localparam logic [OP_W-1:0] OP_NEXT   = 3'd3;
  localparam logic [OP_W-1:0] OP_PREV   = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [KEY_W-1:0] key;
  } in_t;

  typedef struct packed {
    logic             found;
    logic [KEY_W-1:0] position;
  } out_t;

  typedef struct packed {
    logic load_in;
    logic rd_en;
    logic rd_child;
    logic ev1;
    logic ev2;
    logic load_out;
  } hbs_cmd_t;

  typedef struct packed {
    logic upd;
    logic qry;
    logic search;
    logic leaf_hit;
    logic root_hit;
  } hbs_sts_t;

  function automatic logic [BIT_W-1:0] low_bit(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] b;
    b = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) b = BIT_W'(i);
    end
    return b;
  endfunction

  function automatic logic [BIT_W-1:0] high_bit(input logic [WORD_W-1:0] w);
    logic [BIT_W-1:0] b;
    b = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (w[i]) b = BIT_W'(i);
    end
    return b;
  endfunction

endpackage

/* rtl/core/hbs_ctrl.sv */
// controller state machine sequencing leaf reads, updates and result hand-off
module hbs_ctrl import hbs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  hbs_sts_t sts,
  output hbs_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_RD1  = 6'b000010,
    S_EV1  = 6'b000100,
    S_RD2  = 6'b001000,
    S_EV2  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_RD1;
        end
      end
      S_RD1: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_EV1;
      end
      S_EV1: begin
        cmd.ev1 = 1'b1;
        if (sts.upd || !sts.qry) begin
          state_nxt = S_IDLE;
        end else if (sts.search && !sts.leaf_hit && sts.root_hit) begin
          state_nxt = S_RD2;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_RD2: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_child = 1'b1;
        state_nxt    = S_EV2;
      end
      S_EV2: begin
        cmd.ev2   = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> !(out_valid_r && out_stall))
    else $error("result register overwritten while stalled");

  a_accept_starts_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == S_RD1))
    else $error("accepted transaction did not start a leaf read");

  a_child_read_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD2) |-> ($past(state_r) == S_EV1))
    else $error("child read without a preceding root search");

endmodule

/* rtl/core/hbs_dp.sv */
// datapath with root word, leaf word memory, bit search and result registers
module hbs_dp import hbs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  in_t      in_data,
  input  hbs_cmd_t cmd,
  output hbs_sts_t sts,
  output out_t     out_data
);

  logic [WORD_W-1:0]     leaf_mem [LEAF_WORDS];
  logic [LEAF_WORDS-1:0] leaf_vld_r;
  logic [WORD_W-1:0]     root_r;
  logic [WORD_W-1:0]     rd_data_r;
  logic                  rd_vld_r;
  logic [OP_W-1:0]       op_r;
  logic [KEY_W-1:0]      key_r;
  logic [LEAF_W-1:0]     child_r;
  out_t                  res_r, res_nxt;
  out_t                  out_r;

  logic [LEAF_W-1:0] key_hi;
  logic [BIT_W-1:0]  key_lo;
  logic [LEAF_W-1:0] rd_addr;
  logic [WORD_W-1:0] leaf;
  logic [WORD_W-1:0] key_bit;
  logic [WORD_W-1:0] wdata;
  logic [WORD_W-1:0] leaf_m;
  logic [WORD_W-1:0] root_m;
  logic [BIT_W-1:0]  leaf_b;
  logic [LEAF_W-1:0] root_b;
  logic [BIT_W-1:0]  leaf2_b;
  logic              is_next;
  logic              is_ins;
  logic              wr_en;

  assign key_hi  = key_r[KEY_W-1:BIT_W];
  assign key_lo  = key_r[BIT_W-1:0];
  assign rd_addr = cmd.rd_child ? child_r : key_hi;
  assign leaf    = rd_vld_r ? rd_data_r : '0;
  assign key_bit = {{(WORD_W-1){1'b0}}, 1'b1} << key_lo;
  assign is_next = (op_r == OP_NEXT);
  assign is_ins  = (op_r == OP_INSERT);

  assign sts.upd    = op_r inside {OP_INSERT, OP_ERASE};
  assign sts.qry    = op_r inside {OP_TEST, OP_NEXT, OP_PREV};
  assign sts.search = op_r inside {OP_NEXT, OP_PREV};

  assign wdata = is_ins ? (leaf | key_bit) : (leaf & ~key_bit);
  assign wr_en = cmd.ev1 && sts.upd;

  // leaf search at or beyond the key, root search strictly beyond its word
  always_comb begin
    if (is_next) begin
      leaf_m = leaf & ({WORD_W{1'b1}} << key_lo);
      root_m = root_r & (({WORD_W{1'b1}} << key_hi) << 1);
    end else begin
      leaf_m = leaf & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - key_lo));
      root_m = root_r & ~({WORD_W{1'b1}} << key_hi);
    end
  end

  assign leaf_b  = is_next ? low_bit(leaf_m) : high_bit(leaf_m);
  assign root_b  = is_next ? low_bit(root_m) : high_bit(root_m);
  assign leaf2_b = is_next ? low_bit(leaf) : high_bit(leaf);

  assign sts.leaf_hit = |leaf_m;
  assign sts.root_hit = |root_m;

  always_comb begin
    res_nxt = res_r;
    if (cmd.ev1) begin
      if (op_r == OP_TEST) begin
        res_nxt.found    = |(leaf & key_bit);
        res_nxt.position = key_r;
      end else if (sts.leaf_hit) begin
        res_nxt.found    = 1'b1;
        res_nxt.position = {key_hi, leaf_b};
      end else begin
        res_nxt.found    = 1'b0;
        res_nxt.position = '0;
      end
    end else if (cmd.ev2) begin
      res_nxt.found    = 1'b1;
      res_nxt.position = {child_r, leaf2_b};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      leaf_mem[key_hi] <= wdata;
    end
    if (cmd.rd_en) begin
      rd_data_r <= leaf_mem[rd_addr];
      rd_vld_r  <= leaf_vld_r[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      leaf_vld_r <= '0;
      root_r     <= '0;
    end else if (wr_en) begin
      leaf_vld_r[key_hi] <= 1'b1;
      root_r[key_hi]     <= |wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r  <= in_data.operation;
      key_r <= in_data.key;
    end
    if (cmd.ev1) begin
      child_r <= root_b;
    end
    res_r <= res_nxt;
    if (cmd.load_out) begin
      out_r <= res_r;
    end
  end

  assign out_data = out_r;

  a_child_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ev2 |-> (leaf != '0))
    else $error("root marks an empty leaf word");

  a_insert_marks_root: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && is_ins) |=> root_r[key_hi])
    else $error("insert left root bit clear");

  a_erase_empty_clears_root: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && !is_ins && (wdata == '0)) |=> !root_r[key_hi])
    else $error("emptied leaf word still marked in root");

endmodule

/* rtl/core/hierarchical_bitset_successor.sv */
// top level of the two-level 64-ary bitset with membership and neighbor search
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall   | in_t  {operation, key}
//   out_    | output    | out_valid / out_stall | out_t {found, position}
//
// one transaction at a time: insert and erase pass the read and evaluate states;
// test and a search ending in the key's leaf word or with no root hit add the output
// state; a search through the root adds a child read and evaluate before it, so the
// leaf word memory is read once for the key's word, once more for the root's child
// reset clears the root word and the leaf valid bits at once, no sweep
// a result waiting on out_stall holds the block in its output state; input is
// taken again once the result register is loaded
module hierarchical_bitset_successor import hbs_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  hbs_cmd_t cmd;
  hbs_sts_t sts;

  hbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  hbs_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule
